// ===== sv/laser_tec_safety_interlock_assert.svh =====
// Assertion macros for the interlock checker.
`ifndef LASER_TEC_SAFETY_INTERLOCK_ASSERT_SVH
`define LASER_TEC_SAFETY_INTERLOCK_ASSERT_SVH

// Clocked assertion that is not checked while reset is held.
`define LTSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define LTSI_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/ltsi_pkg.sv =====
// Types, constants and codes of the laser and TEC safety interlock.
package ltsi_pkg;

  localparam int DAC_BITS   = 12;
  localparam int CUR_W      = 15;
  localparam int TEMP_W     = 16;
  localparam int MEAS_W     = 16;
  localparam int TIME_W     = 32;
  localparam int CAUSE_W    = 5;
  localparam int FLAGS_W    = 4;
  localparam int PROD_W     = CUR_W + DAC_BITS;
  localparam int CNT_W      = $clog2(DAC_BITS);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [DAC_BITS-1:0] DAC_FULL = '1;

  localparam logic [CUR_W-1:0]  RST_TEC_MAX     = 15'd5000;
  localparam logic [CUR_W-1:0]  RST_LASER_MAX   = 15'd10000;
  localparam logic [CUR_W-1:0]  RST_TEC_TRIP    = 15'd5500;
  localparam logic [CUR_W-1:0]  RST_LASER_TRIP  = 15'd11000;
  localparam logic [TEMP_W-1:0] RST_TEMP_HIGH   = 16'sd8000;
  localparam logic [TEMP_W-1:0] RST_TEMP_LOW    = -16'sd1000;
  localparam logic [TIME_W-1:0] RST_WATCHDOG    = 32'd5000;

  // Bit positions in fault_causes and status_flags.
  localparam int CAUSE_TEC_OC   = 0;
  localparam int CAUSE_LASER_OC = 1;
  localparam int CAUSE_TEMP     = 2;
  localparam int CAUSE_HW       = 3;
  localparam int CAUSE_WDOG     = 4;

  localparam int FLAG_TEC   = 0;
  localparam int FLAG_LASER = 1;
  localparam int FLAG_FAULT = 2;
  localparam int FLAG_READY = 3;

  typedef enum logic [3:0] {
    CMD_TICK      = 4'd0,
    CMD_TEC_SET   = 4'd1,
    CMD_LASER_SET = 4'd2,
    CMD_TEC_ON    = 4'd3,
    CMD_TEC_OFF   = 4'd4,
    CMD_LASER_ON  = 4'd5,
    CMD_LASER_OFF = 4'd6,
    CMD_STATUS    = 4'd7,
    CMD_RESET     = 4'd8,
    CMD_MON_ON    = 4'd9,
    CMD_MON_OFF   = 4'd10
  } cmd_t;

  typedef enum logic [2:0] {
    RSP_OK       = 3'd0,
    RSP_REFUSED  = 3'd1,
    RSP_UNKNOWN  = 3'd2,
    RSP_STATUS   = 3'd3,
    RSP_SAFE     = 3'd4,
    RSP_SHUTDOWN = 3'd5
  } resp_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEC_MAX    = 3'd0,
    REG_LASER_MAX  = 3'd1,
    REG_TEC_TRIP   = 3'd2,
    REG_LASER_TRIP = 3'd3,
    REG_TEMP_HIGH  = 3'd4,
    REG_TEMP_LOW   = 3'd5,
    REG_WATCHDOG   = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [3:0]               command;
    logic [TIME_W-1:0]        now_ms;
    logic signed [MEAS_W-1:0] setpoint_ma;
    logic signed [MEAS_W-1:0] tec_meas_ma;
    logic signed [MEAS_W-1:0] laser_meas_ma;
    logic signed [TEMP_W-1:0] temp_meas_centi;
    logic                     fault_pin;
  } in_item_t;

  typedef struct packed {
    logic [2:0]          response;
    logic [CAUSE_W-1:0]  fault_causes;
    logic                tec_enable_out;
    logic                laser_enable_out;
    logic                tec_dac_write;
    logic [DAC_BITS-1:0] tec_dac_code;
    logic                laser_dac_write;
    logic [DAC_BITS-1:0] laser_dac_code;
    logic [FLAGS_W-1:0]  status_flags;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ld_item;
    logic ld_mul;
    logic div_step;
    logic commit;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_set;
  } sts_t;

endpackage

// ===== sv/ltsi_ctrl.sv =====
// Controller state machine: sequences load, scaling divide and result commit.
module ltsi_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  ltsi_pkg::sts_t sts,
  output ltsi_pkg::ctl_t ctl
);

  ltsi_pkg::state_t           state_r, state_nxt;
  logic [ltsi_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ltsi_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ltsi_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ctl           = '0;
    case (state_r)
      ltsi_pkg::S_IDLE: begin
        if (in_valid) begin
          ctl.ld_item = 1'b1;
          state_nxt   = ltsi_pkg::S_EVAL;
        end
      end
      ltsi_pkg::S_EVAL: begin
        if (sts.is_set) begin
          ctl.ld_mul = 1'b1;
          cnt_nxt    = '0;
          state_nxt  = ltsi_pkg::S_DIV;
        end else begin
          state_nxt = ltsi_pkg::S_FIN;
        end
      end
      ltsi_pkg::S_DIV: begin
        ctl.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == ltsi_pkg::CNT_W'(ltsi_pkg::DAC_BITS - 1)) begin
          state_nxt = ltsi_pkg::S_FIN;
        end
      end
      ltsi_pkg::S_FIN: begin
        // State is updated only when the result register can take the item.
        if (slot_free) begin
          ctl.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ltsi_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ltsi_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/ltsi_dpath.sv =====
// Datapath: configuration registers, interlock state, scaling divider and result register.
module ltsi_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [ltsi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ltsi_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  ltsi_pkg::in_item_t                  in_data,
  output ltsi_pkg::out_item_t                 out_data,
  input  ltsi_pkg::ctl_t                      ctl,
  output ltsi_pkg::sts_t                      sts
);

  localparam int CW = ltsi_pkg::CUR_W;
  localparam int DB = ltsi_pkg::DAC_BITS;

  logic [CW-1:0]                  tec_max_r, laser_max_r, tec_trip_r, laser_trip_r;
  logic signed [ltsi_pkg::TEMP_W-1:0] temp_high_r, temp_low_r;
  logic [ltsi_pkg::TIME_W-1:0]    watchdog_r;

  logic                           tec_on_r, tec_on_nxt;
  logic                           laser_on_r, laser_on_nxt;
  logic                           fault_r, fault_nxt;
  logic [ltsi_pkg::TIME_W-1:0]    last_cmd_r, last_cmd_nxt;
  logic [DB-1:0]                  tec_code_r, tec_code_nxt;
  logic [DB-1:0]                  laser_code_r, laser_code_nxt;

  ltsi_pkg::in_item_t             item_r;
  ltsi_pkg::out_item_t            out_r, out_nxt;

  logic [CW-1:0]                  rem_r;
  logic [DB-1:0]                  quo_r;

  logic [CW-1:0]                  sel_max;
  logic [CW-1:0]                  clamp_ma;
  logic [ltsi_pkg::PROD_W-1:0]    prod;
  logic [CW:0]                    trial;
  logic                           trial_ge;
  logic [DB-1:0]                  code;
  logic [ltsi_pkg::CAUSE_W-1:0]   causes;
  logic [ltsi_pkg::TIME_W-1:0]    age;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tec_max_r    <= ltsi_pkg::RST_TEC_MAX;
      laser_max_r  <= ltsi_pkg::RST_LASER_MAX;
      tec_trip_r   <= ltsi_pkg::RST_TEC_TRIP;
      laser_trip_r <= ltsi_pkg::RST_LASER_TRIP;
      temp_high_r  <= ltsi_pkg::RST_TEMP_HIGH;
      temp_low_r   <= ltsi_pkg::RST_TEMP_LOW;
      watchdog_r   <= ltsi_pkg::RST_WATCHDOG;
    end else if (cfg_valid) begin
      case (cfg_index)
        ltsi_pkg::REG_TEC_MAX:    tec_max_r    <= cfg_data[CW-1:0];
        ltsi_pkg::REG_LASER_MAX:  laser_max_r  <= cfg_data[CW-1:0];
        ltsi_pkg::REG_TEC_TRIP:   tec_trip_r   <= cfg_data[CW-1:0];
        ltsi_pkg::REG_LASER_TRIP: laser_trip_r <= cfg_data[CW-1:0];
        ltsi_pkg::REG_TEMP_HIGH:  temp_high_r  <= cfg_data[ltsi_pkg::TEMP_W-1:0];
        ltsi_pkg::REG_TEMP_LOW:   temp_low_r   <= cfg_data[ltsi_pkg::TEMP_W-1:0];
        ltsi_pkg::REG_WATCHDOG:   watchdog_r   <= cfg_data[ltsi_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Item register and scaling divider.
  assign sts.is_set = (item_r.command == ltsi_pkg::CMD_TEC_SET) ||
                      (item_r.command == ltsi_pkg::CMD_LASER_SET);

  assign sel_max = (item_r.command == ltsi_pkg::CMD_TEC_SET) ? tec_max_r : laser_max_r;

  always_comb begin
    if (item_r.setpoint_ma[ltsi_pkg::MEAS_W-1]) begin
      clamp_ma = '0;
    end else if (item_r.setpoint_ma[CW-1:0] > sel_max) begin
      clamp_ma = sel_max;
    end else begin
      clamp_ma = item_r.setpoint_ma[CW-1:0];
    end
  end

  assign prod     = ltsi_pkg::PROD_W'(clamp_ma) * ltsi_pkg::PROD_W'(ltsi_pkg::DAC_FULL);
  assign trial    = {rem_r, quo_r[DB-1]};
  assign trial_ge = (trial >= {1'b0, sel_max});
  assign code     = (sel_max == '0) ? '0 : quo_r;

  // The product is below max * 2^DAC_BITS, so the upper bits start as a
  // remainder smaller than max and the quotient fits in DAC_BITS steps.
  always_ff @(posedge clk) begin
    if (ctl.ld_item) begin
      item_r <= in_data;
    end
    if (ctl.ld_mul) begin
      rem_r <= prod[ltsi_pkg::PROD_W-1:DB];
      quo_r <= prod[DB-1:0];
    end else if (ctl.div_step) begin
      rem_r <= trial_ge ? CW'(trial - {1'b0, sel_max}) : trial[CW-1:0];
      quo_r <= {quo_r[DB-2:0], trial_ge};
    end
  end

  // Tick checks.
  assign age = item_r.now_ms - last_cmd_r;

  always_comb begin
    causes = '0;
    causes[ltsi_pkg::CAUSE_TEC_OC]   = item_r.tec_meas_ma > $signed({1'b0, tec_trip_r});
    causes[ltsi_pkg::CAUSE_LASER_OC] = item_r.laser_meas_ma > $signed({1'b0, laser_trip_r});
    causes[ltsi_pkg::CAUSE_TEMP]     = (item_r.temp_meas_centi > temp_high_r) ||
                                       (item_r.temp_meas_centi < temp_low_r);
    causes[ltsi_pkg::CAUSE_HW]       = item_r.fault_pin;
    causes[ltsi_pkg::CAUSE_WDOG]     = age > watchdog_r;
  end

  // Next state and result of the item.
  always_comb begin
    tec_on_nxt     = tec_on_r;
    laser_on_nxt   = laser_on_r;
    fault_nxt      = fault_r;
    last_cmd_nxt   = last_cmd_r;
    tec_code_nxt   = tec_code_r;
    laser_code_nxt = laser_code_r;
    out_nxt        = '0;
    out_nxt.response = ltsi_pkg::RSP_OK;
    if (item_r.command != ltsi_pkg::CMD_TICK) begin
      last_cmd_nxt = item_r.now_ms;
    end
    case (item_r.command)
      ltsi_pkg::CMD_TICK: begin
        if (causes != '0) begin
          out_nxt.response      = ltsi_pkg::RSP_SHUTDOWN;
          out_nxt.fault_causes  = causes;
          tec_on_nxt            = 1'b0;
          laser_on_nxt          = 1'b0;
          fault_nxt             = 1'b1;
          out_nxt.tec_dac_write   = 1'b1;
          out_nxt.laser_dac_write = 1'b1;
        end else begin
          out_nxt.response = ltsi_pkg::RSP_SAFE;
        end
      end
      ltsi_pkg::CMD_TEC_SET: begin
        tec_code_nxt = code;
        if (tec_on_r) begin
          out_nxt.tec_dac_write = 1'b1;
          out_nxt.tec_dac_code  = code;
        end
      end
      ltsi_pkg::CMD_LASER_SET: begin
        laser_code_nxt = code;
        if (laser_on_r) begin
          out_nxt.laser_dac_write = 1'b1;
          out_nxt.laser_dac_code  = code;
        end
      end
      ltsi_pkg::CMD_TEC_ON: begin
        if (fault_r) begin
          out_nxt.response = ltsi_pkg::RSP_REFUSED;
        end else begin
          tec_on_nxt            = 1'b1;
          out_nxt.tec_dac_write = 1'b1;
          out_nxt.tec_dac_code  = tec_code_r;
        end
      end
      ltsi_pkg::CMD_TEC_OFF: begin
        tec_on_nxt            = 1'b0;
        out_nxt.tec_dac_write = 1'b1;
      end
      ltsi_pkg::CMD_LASER_ON: begin
        if (fault_r) begin
          out_nxt.response = ltsi_pkg::RSP_REFUSED;
        end else begin
          laser_on_nxt            = 1'b1;
          out_nxt.laser_dac_write = 1'b1;
          out_nxt.laser_dac_code  = laser_code_r;
        end
      end
      ltsi_pkg::CMD_LASER_OFF: begin
        laser_on_nxt            = 1'b0;
        out_nxt.laser_dac_write = 1'b1;
      end
      ltsi_pkg::CMD_STATUS: begin
        out_nxt.response = ltsi_pkg::RSP_STATUS;
      end
      ltsi_pkg::CMD_RESET: begin
        fault_nxt = 1'b0;
      end
      ltsi_pkg::CMD_MON_ON, ltsi_pkg::CMD_MON_OFF: ;
      default: begin
        out_nxt.response = ltsi_pkg::RSP_UNKNOWN;
      end
    endcase
    out_nxt.tec_enable_out   = tec_on_nxt;
    out_nxt.laser_enable_out = laser_on_nxt;
    out_nxt.status_flags[ltsi_pkg::FLAG_TEC]   = tec_on_nxt;
    out_nxt.status_flags[ltsi_pkg::FLAG_LASER] = laser_on_nxt;
    out_nxt.status_flags[ltsi_pkg::FLAG_FAULT] = fault_nxt;
    out_nxt.status_flags[ltsi_pkg::FLAG_READY] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tec_on_r     <= 1'b0;
      laser_on_r   <= 1'b0;
      fault_r      <= 1'b0;
      last_cmd_r   <= '0;
      tec_code_r   <= '0;
      laser_code_r <= '0;
    end else if (ctl.commit) begin
      tec_on_r     <= tec_on_nxt;
      laser_on_r   <= laser_on_nxt;
      fault_r      <= fault_nxt;
      last_cmd_r   <= last_cmd_nxt;
      tec_code_r   <= tec_code_nxt;
      laser_code_r <= laser_code_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

// ===== sv/laser_tec_safety_interlock.sv =====
// Top level of the laser and TEC safety interlock.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_data (ltsi_pkg::in_item_t)
//   out      output     out_valid / out_ready  out_data (ltsi_pkg::out_item_t)
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item is loaded, evaluated, divided (set commands only) and committed before the next
// is accepted; the restoring divider makes one quotient bit per cycle.
// Reset is synchronous and restores the register defaults; no clearing pass.
// A result waits in the output register; a finished item stalls in its last
// state until that register is free. Configuration writes are always taken.
module laser_tec_safety_interlock (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ltsi_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ltsi_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ltsi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ltsi_pkg::CFG_DATA_W-1:0] cfg_data
);

  ltsi_pkg::ctl_t ctl;
  ltsi_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  ltsi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  ltsi_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .ctl       (ctl),
    .sts       (sts)
  );

endmodule

// ===== sv/ltsi_checker.sv =====
// Port-level checker for the interlock and its bind to the top level.
`include "laser_tec_safety_interlock_assert.svh"

module ltsi_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input ltsi_pkg::out_item_t out_data
);

  `LTSI_ASSERT_RST(a_no_result_after_reset, !rst_n |=> !out_valid, "result valid after reset")

  `LTSI_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled item changed")

  `LTSI_ASSERT(a_shutdown_safe, out_valid && out_data.response == ltsi_pkg::RSP_SHUTDOWN |-> !out_data.tec_enable_out && !out_data.laser_enable_out && out_data.tec_dac_write && out_data.laser_dac_write && out_data.tec_dac_code == '0 && out_data.laser_dac_code == '0, "shutdown left a channel driven")

  `LTSI_ASSERT(a_causes_shutdown, out_valid && out_data.fault_causes != '0 |-> out_data.response == ltsi_pkg::RSP_SHUTDOWN && out_data.status_flags[ltsi_pkg::FLAG_FAULT], "fault cause without latched shutdown")

  `LTSI_ASSERT(a_flags_match, out_valid |-> out_data.status_flags[ltsi_pkg::FLAG_READY] && out_data.status_flags[ltsi_pkg::FLAG_TEC] == out_data.tec_enable_out && out_data.status_flags[ltsi_pkg::FLAG_LASER] == out_data.laser_enable_out, "status flags disagree with enables")

endmodule

bind laser_tec_safety_interlock ltsi_checker u_ltsi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== bench/laser_tec_safety_interlock_tb.sv =====
// Self-checking testbench: directed and random command traffic against a predictor of the interlock.
module laser_tec_safety_interlock_tb;
  import ltsi_pkg::*;

  localparam logic [3:0] CMD_UNKNOWN_FIRST = 4'd11;
  localparam logic [3:0] CMD_UNKNOWN_LAST  = 4'd15;
  localparam logic signed [MEAS_W-1:0] MEAS_MIN = 16'sh8000;
  localparam logic signed [MEAS_W-1:0] MEAS_MAX = 16'sh7FFF;
  localparam int MAX_GAP       = 13;
  localparam int SETTLE_CYCLES = 2 * (DAC_BITS + 3);
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 250;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  laser_tec_safety_interlock dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register copy of the interlock.
  logic [CUR_W-1:0]         tec_max;
  logic [CUR_W-1:0]         laser_max;
  logic [CUR_W-1:0]         tec_trip;
  logic [CUR_W-1:0]         laser_trip;
  logic signed [TEMP_W-1:0] temp_high;
  logic signed [TEMP_W-1:0] temp_low;
  logic [TIME_W-1:0]        watchdog_limit;

  // Channel and latch state of the interlock.
  logic                tec_on;
  logic                laser_on;
  logic                fault_latched;
  logic [TIME_W-1:0]   last_cmd_ms;
  logic [DAC_BITS-1:0] tec_code;
  logic [DAC_BITS-1:0] laser_code;

  out_item_t pending_responses[$];

  int errors         = 0;
  int items_sent     = 0;
  int responses_seen = 0;
  int shutdowns_seen = 0;
  int refusals_seen  = 0;
  int reg_writes     = 0;
  bit burst          = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [DAC_BITS-1:0] ma_to_code(logic signed [MEAS_W-1:0] ma,
                                                     logic [CUR_W-1:0] full);
    longint m;
    m = ma;
    if (full == '0) return '0;
    if (m < 0) m = 0;
    if (m > longint'(full)) m = longint'(full);
    return DAC_BITS'((m * longint'(DAC_FULL)) / longint'(full));
  endfunction

  // Advances the channel state by one item and returns the response it causes.
  function automatic out_item_t predict_interlock(in_item_t it);
    out_item_t          r;
    logic [CAUSE_W-1:0] causes;
    logic [TIME_W-1:0]  age;
    r = '0;
    causes = '0;
    if (it.command == CMD_TICK) begin
      age = it.now_ms - last_cmd_ms;
      if (int'(it.tec_meas_ma) > int'(tec_trip)) causes[CAUSE_TEC_OC] = 1'b1;
      if (int'(it.laser_meas_ma) > int'(laser_trip)) causes[CAUSE_LASER_OC] = 1'b1;
      if (it.temp_meas_centi > temp_high || it.temp_meas_centi < temp_low)
        causes[CAUSE_TEMP] = 1'b1;
      if (it.fault_pin) causes[CAUSE_HW] = 1'b1;
      if (age > watchdog_limit) causes[CAUSE_WDOG] = 1'b1;
      if (causes != '0) begin
        r.response = RSP_SHUTDOWN;
        tec_on = 1'b0;
        laser_on = 1'b0;
        fault_latched = 1'b1;
        r.tec_dac_write = 1'b1;
        r.laser_dac_write = 1'b1;
      end else begin
        r.response = RSP_SAFE;
      end
    end else begin
      last_cmd_ms = it.now_ms;
      r.response = RSP_OK;
      case (it.command)
        CMD_TEC_SET: begin
          tec_code = ma_to_code(it.setpoint_ma, tec_max);
          if (tec_on) begin
            r.tec_dac_write = 1'b1;
            r.tec_dac_code = tec_code;
          end
        end
        CMD_LASER_SET: begin
          laser_code = ma_to_code(it.setpoint_ma, laser_max);
          if (laser_on) begin
            r.laser_dac_write = 1'b1;
            r.laser_dac_code = laser_code;
          end
        end
        CMD_TEC_ON: begin
          if (fault_latched) begin
            r.response = RSP_REFUSED;
          end else begin
            tec_on = 1'b1;
            r.tec_dac_write = 1'b1;
            r.tec_dac_code = tec_code;
          end
        end
        CMD_TEC_OFF: begin
          tec_on = 1'b0;
          r.tec_dac_write = 1'b1;
        end
        CMD_LASER_ON: begin
          if (fault_latched) begin
            r.response = RSP_REFUSED;
          end else begin
            laser_on = 1'b1;
            r.laser_dac_write = 1'b1;
            r.laser_dac_code = laser_code;
          end
        end
        CMD_LASER_OFF: begin
          laser_on = 1'b0;
          r.laser_dac_write = 1'b1;
        end
        CMD_STATUS: r.response = RSP_STATUS;
        CMD_RESET: fault_latched = 1'b0;
        CMD_MON_ON, CMD_MON_OFF: ;
        default: r.response = RSP_UNKNOWN;
      endcase
    end
    r.fault_causes = causes;
    r.tec_enable_out = tec_on;
    r.laser_enable_out = laser_on;
    r.status_flags[FLAG_TEC] = tec_on;
    r.status_flags[FLAG_LASER] = laser_on;
    r.status_flags[FLAG_FAULT] = fault_latched;
    r.status_flags[FLAG_READY] = 1'b1;
    return r;
  endfunction

  function automatic in_item_t make_item(logic [3:0] cmd, logic [TIME_W-1:0] now,
                                         logic signed [MEAS_W-1:0] sp = '0,
                                         logic signed [MEAS_W-1:0] tec = '0,
                                         logic signed [MEAS_W-1:0] las = '0,
                                         logic signed [TEMP_W-1:0] temp = 16'sd2500,
                                         logic pin = 1'b0);
    in_item_t it;
    it.command = cmd;
    it.now_ms = now;
    it.setpoint_ma = sp;
    it.tec_meas_ma = tec;
    it.laser_meas_ma = las;
    it.temp_meas_centi = temp;
    it.fault_pin = pin;
    return it;
  endfunction

  // Mostly well-formed traffic: safe ticks, set and switch commands, recovery
  // after a fault, with some violations, unknown codes and raw noise mixed in.
  function automatic in_item_t next_traffic_item();
    in_item_t it;
    int       pick;
    int       v;
    int       lo;
    int       hi;
    it.command = CMD_STATUS;
    it.now_ms = last_cmd_ms + $urandom_range(0, 3000);
    it.setpoint_ma = $urandom();
    it.tec_meas_ma = $urandom();
    it.laser_meas_ma = $urandom();
    it.temp_meas_centi = $urandom();
    it.fault_pin = $urandom_range(0, 1);
    pick = $urandom_range(0, 99);
    if (fault_latched && $urandom_range(0, 2) == 0) begin
      it.command = CMD_RESET;
    end else if (pick < 3) begin
      it.command = $urandom_range(0, 15);
      it.now_ms = $urandom();
    end else if (pick < 38) begin
      it.command = CMD_TICK;
      it.now_ms = last_cmd_ms + $urandom_range(0, watchdog_limit);
      it.fault_pin = 1'b0;
      if ($urandom_range(0, 1) == 0) it.tec_meas_ma = -int'($urandom_range(0, 32768));
      else it.tec_meas_ma = $urandom_range(0, tec_trip);
      if ($urandom_range(0, 1) == 0) it.laser_meas_ma = -int'($urandom_range(0, 32768));
      else it.laser_meas_ma = $urandom_range(0, laser_trip);
      lo = temp_low;
      hi = temp_high;
      if (lo <= hi) it.temp_meas_centi = lo + int'($urandom_range(0, hi - lo));
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 4))
          0: if (tec_trip != '1) it.tec_meas_ma = $urandom_range(tec_trip + 1, 32767);
          1: if (laser_trip != '1) it.laser_meas_ma = $urandom_range(laser_trip + 1, 32767);
          2: begin
            if (hi < 32767 && $urandom_range(0, 1) == 0)
              it.temp_meas_centi = $urandom_range(hi + 1, 32767);
            else if (lo > -32768)
              it.temp_meas_centi = -32768 + int'($urandom_range(0, lo + 32767));
          end
          3: it.fault_pin = 1'b1;
          default: begin
            if (watchdog_limit != '1)
              it.now_ms = last_cmd_ms + watchdog_limit + 32'd1 + $urandom_range(0, 100);
          end
        endcase
        if ($urandom_range(0, 3) == 0) it.fault_pin = 1'b1;
      end
    end else if (pick < 53) begin
      it.command = $urandom_range(0, 1) ? CMD_TEC_SET : CMD_LASER_SET;
      if ($urandom_range(0, 5) != 0) begin
        v = (it.command == CMD_TEC_SET) ? tec_max : laser_max;
        v = $urandom_range(0, v + v / 4);
        it.setpoint_ma = (v > 32767) ? 32767 : v;
      end
    end else if (pick < 75) begin
      it.command = $urandom_range(0, 1) ? CMD_TEC_ON : CMD_LASER_ON;
    end else if (pick < 83) begin
      it.command = $urandom_range(0, 1) ? CMD_TEC_OFF : CMD_LASER_OFF;
    end else if (pick < 87) begin
      it.command = CMD_STATUS;
    end else if (pick < 91) begin
      it.command = CMD_RESET;
    end else if (pick < 95) begin
      it.command = $urandom_range(0, 1) ? CMD_MON_ON : CMD_MON_OFF;
    end else if (pick < 97) begin
      it.command = $urandom_range(CMD_UNKNOWN_FIRST, CMD_UNKNOWN_LAST);
    end else begin
      it.command = CMD_TICK;
      it.now_ms = $urandom();
    end
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    pending_responses.push_back(predict_interlock(it));
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high; write_settings lowers it after the last register.
  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TEC_MAX:    tec_max = value[CUR_W-1:0];
      REG_LASER_MAX:  laser_max = value[CUR_W-1:0];
      REG_TEC_TRIP:   tec_trip = value[CUR_W-1:0];
      REG_LASER_TRIP: laser_trip = value[CUR_W-1:0];
      REG_TEMP_HIGH:  temp_high = value[TEMP_W-1:0];
      REG_TEMP_LOW:   temp_low = value[TEMP_W-1:0];
      REG_WATCHDOG:   watchdog_limit = value;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic write_settings(input logic [CUR_W-1:0] t_max, l_max, t_trip, l_trip,
                                input logic signed [TEMP_W-1:0] t_hi, t_lo,
                                input logic [TIME_W-1:0] wd);
    write_reg(REG_TEC_MAX, CFG_DATA_W'(t_max));
    write_reg(REG_LASER_MAX, CFG_DATA_W'(l_max));
    write_reg(REG_TEC_TRIP, CFG_DATA_W'(t_trip));
    write_reg(REG_LASER_TRIP, CFG_DATA_W'(l_trip));
    write_reg(REG_TEMP_HIGH, CFG_DATA_W'(t_hi));
    write_reg(REG_TEMP_LOW, CFG_DATA_W'(t_lo));
    write_reg(REG_WATCHDOG, wd);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_power_up_defaults();
    send_item(make_item(CMD_STATUS, 32'd10));
    send_item(make_item(CMD_TEC_SET, 32'd20, MEAS_MAX));
    send_item(make_item(CMD_TEC_ON, 32'd30));
    send_item(make_item(CMD_TEC_SET, 32'd40, MEAS_MIN));
    send_item(make_item(CMD_TEC_SET, 32'd50, 16'sd2500));
    send_item(make_item(CMD_LASER_SET, 32'd60, MEAS_MAX));
    send_item(make_item(CMD_LASER_ON, 32'd70));
    // The TEC current, temperature and watchdog limits are met exactly, so nothing trips.
    send_item(make_item(CMD_TICK, 32'd5070, '0, 16'sd5500, MEAS_MIN, -16'sd1000));
  endtask

  task automatic test_channel_commands();
    send_item(make_item(CMD_TEC_OFF, 32'd100));
    send_item(make_item(CMD_TEC_OFF, 32'd110));
    send_item(make_item(CMD_LASER_OFF, 32'd120));
    send_item(make_item(CMD_MON_ON, 32'd130));
    send_item(make_item(CMD_MON_OFF, 32'd140));
    send_item(make_item(CMD_UNKNOWN_FIRST, 32'd150));
    send_item(make_item(CMD_UNKNOWN_LAST, 32'd160, MEAS_MIN, MEAS_MAX, MEAS_MAX, MEAS_MIN,
                        1'b1));
  endtask

  task automatic test_fault_latch();
    send_item(make_item(CMD_TEC_ON, 32'd170));
    send_item(make_item(CMD_LASER_ON, 32'd180));
    send_item(make_item(CMD_TICK, 32'd200, '0, 16'sd5501));
    send_item(make_item(CMD_TICK, 32'd210, '0, '0, 16'sd11001));
    send_item(make_item(CMD_TICK, 32'd220, '0, '0, '0, 16'sd8001));
    send_item(make_item(CMD_TICK, 32'd230, '0, '0, '0, -16'sd1001));
    send_item(make_item(CMD_TICK, 32'd240, '0, '0, '0, 16'sd2500, 1'b1));
    send_item(make_item(CMD_TICK, 32'd5181));
    send_item(make_item(CMD_LASER_ON, 32'd5200));
    send_item(make_item(CMD_TEC_ON, 32'd5210));
    send_item(make_item(CMD_STATUS, 32'd5220));
    send_item(make_item(CMD_RESET, 32'd5230));
    send_item(make_item(CMD_TEC_ON, 32'd5240));
    send_item(make_item(CMD_LASER_ON, 32'd5250));
  endtask

  task automatic test_register_extremes();
    wait_idle();
    write_settings(15'd1, 15'h7FFF, '0, 15'h7FFF, MEAS_MAX, MEAS_MIN, '1);
    send_item(make_item(CMD_TEC_SET, 32'hFFFF_FFF0, 16'sd1));
    send_item(make_item(CMD_LASER_SET, 32'hFFFF_FFF8, MEAS_MAX));
    // The timestamp wraps past zero here.
    send_item(make_item(CMD_TICK, 32'h10, '0, '0, MEAS_MAX, MEAS_MIN));
    send_item(make_item(CMD_TICK, 32'h20, '0, 16'sd1, '0, MEAS_MAX));
    wait_idle();
    // A zero full scale must give a zero code; a zero watchdog trips on any nonzero age.
    write_settings('0, '0, RST_TEC_TRIP, RST_LASER_TRIP, RST_TEMP_HIGH, RST_TEMP_LOW, '0);
    send_item(make_item(CMD_TEC_SET, 32'd1000, 16'sd100));
    send_item(make_item(CMD_LASER_SET, 32'd1000, MEAS_MAX));
    send_item(make_item(CMD_TICK, 32'd1000));
    send_item(make_item(CMD_TICK, 32'd1001));
  endtask

  task automatic test_random_traffic();
    int                       phase;
    int                       n;
    logic signed [TEMP_W-1:0] a;
    logic signed [TEMP_W-1:0] b;
    logic signed [TEMP_W-1:0] t;
    logic [TIME_W-1:0]        wd;
    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: write_settings(RST_TEC_MAX, RST_LASER_MAX, RST_TEC_TRIP, RST_LASER_TRIP,
                          RST_TEMP_HIGH, RST_TEMP_LOW, RST_WATCHDOG);
        1: write_settings('1, '1, '1, '1, MEAS_MAX, MEAS_MIN, '1);
        2: write_settings(15'd1, 15'd1, '0, '0, '0, '0, '0);
        default: begin
          a = $urandom();
          b = $urandom();
          // Now and then the window is left inverted, so every tick trips.
          if (a > b && $urandom_range(0, 7) != 0) begin
            t = a;
            a = b;
            b = t;
          end
          wd = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(50, 20000);
          write_settings($urandom_range(1, 32767), $urandom_range(1, 32767),
                         $urandom_range(0, 32767), $urandom_range(0, 32767), b, a, wd);
        end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
        send_item(next_traffic_item());
      end
      burst = 1'b0;
    end
  endtask

  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = burst ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_responses
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      responses_seen++;
      if (pending_responses.size() == 0) begin
        $display("%0t: response expected none, got %h", $time, out_data);
        errors++;
      end else begin
        want = pending_responses.pop_front();
        check_field("response", want.response, out_data.response);
        check_field("fault_causes", want.fault_causes, out_data.fault_causes);
        check_field("tec_enable_out", want.tec_enable_out, out_data.tec_enable_out);
        check_field("laser_enable_out", want.laser_enable_out, out_data.laser_enable_out);
        check_field("tec_dac_write", want.tec_dac_write, out_data.tec_dac_write);
        check_field("tec_dac_code", want.tec_dac_code, out_data.tec_dac_code);
        check_field("laser_dac_write", want.laser_dac_write, out_data.laser_dac_write);
        check_field("laser_dac_code", want.laser_dac_code, out_data.laser_dac_code);
        check_field("status_flags", want.status_flags, out_data.status_flags);
        if (out_data.response == RSP_SHUTDOWN) shutdowns_seen++;
        if (out_data.response == RSP_REFUSED) refusals_seen++;
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_TEC_MAX;
    cfg_data <= '0;
    tec_max = RST_TEC_MAX;
    laser_max = RST_LASER_MAX;
    tec_trip = RST_TEC_TRIP;
    laser_trip = RST_LASER_TRIP;
    temp_high = RST_TEMP_HIGH;
    temp_low = RST_TEMP_LOW;
    watchdog_limit = RST_WATCHDOG;
    tec_on = 1'b0;
    laser_on = 1'b0;
    fault_latched = 1'b0;
    last_cmd_ms = '0;
    tec_code = '0;
    laser_code = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_power_up_defaults();
    test_channel_commands();
    test_fault_latch();
    test_register_extremes();
    test_random_traffic();
    wait_idle();
    $display("Covered %0d items over %0d register settings, %0d register writes in all.",
             items_sent, PHASES + 2, reg_writes);
    $display("Checked %0d responses: %0d shutdowns, %0d refused switch-ons, %0d mismatches.",
             responses_seen, shutdowns_seen, refusals_seen, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
